### src/mie_pkg.sv
// Package with shared widths and controller/datapath interface types for the inverse unit.
`default_nettype none
package mie_pkg;
    localparam int VALUE_W     = 62;
    localparam int PRIME_W     = 31;
    localparam int PRIME_W_DEF = 31;
    localparam int COEF_W      = 64;
    localparam int CNT_W       = $clog2(VALUE_W);

    typedef struct packed {
        logic load;
        logic mul;
        logic div_init;
        logic div_step;
        logic swap;
        logic fix_a;
        logic fix_b;
        logic flag;
    } t_cmd;

    typedef struct packed {
        logic m_zero;
        logic r1_zero;
        logic gcd_one;
    } t_status;
endpackage
`default_nettype wire

### src/mie_datapath.sv
// Datapath: modulus multiply, shift-subtract division with coefficient update, final reduction.
`default_nettype none
module mie_datapath #(
    parameter int PRIME_WIDTH = mie_pkg::PRIME_W_DEF
) (
    input  wire logic                          i_clk,
    input  wire mie_pkg::t_cmd                 i_cmd,
    output mie_pkg::t_status                   o_status,
    input  wire logic [mie_pkg::VALUE_W-1:0]   i_exponent,
    input  wire logic [mie_pkg::PRIME_W-1:0]   i_prime_a,
    input  wire logic [mie_pkg::PRIME_W-1:0]   i_prime_b,
    output logic      [mie_pkg::VALUE_W-1:0]   o_inverse,
    output logic                               o_no_inverse
);
    import mie_pkg::*;

    logic [PRIME_WIDTH-1:0] r_fa, r_fb, n_fa, n_fb;
    logic [VALUE_W-1:0]     r_m, r_r0, r_r1, r_pr, r_dv;
    logic [COEF_W-1:0]      r_s0, r_s1, r_t, r_mag;
    logic                   r_neg;
    logic [VALUE_W-1:0]     r_inv;
    logic                   r_no;
    logic [PRIME_WIDTH-1:0] pa, pb;
    logic [VALUE_W:0]       pr_sh;
    logic                   ge;
    logic [VALUE_W-1:0]     prod;
    logic [COEF_W-1:0]      m_ext, mag2, res;

    assign pa    = i_prime_a[PRIME_WIDTH-1:0];
    assign pb    = i_prime_b[PRIME_WIDTH-1:0];
    assign n_fa  = (pa != '0) ? pa - 1'b1 : '0;
    assign n_fb  = (pb != '0) ? pb - 1'b1 : '0;
    assign prod  = VALUE_W'(r_fa) * VALUE_W'(r_fb);
    assign pr_sh = {r_pr, r_dv[VALUE_W-1]};
    assign ge    = pr_sh >= {1'b0, r_r1};
    assign m_ext = COEF_W'(r_m);
    assign mag2  = (r_mag >= m_ext) ? r_mag - m_ext : r_mag;
    assign res   = r_neg ? ((mag2 != '0) ? m_ext - mag2 : '0) : mag2;

    assign o_status.m_zero  = (r_r1 == '0);
    assign o_status.r1_zero = (r_r1 == '0);
    assign o_status.gcd_one = (r_r0 == VALUE_W'(1));
    assign o_inverse    = r_inv;
    assign o_no_inverse = r_no;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_fa <= n_fa;
            r_fb <= n_fb;
            r_r0 <= i_exponent;
            r_s0 <= COEF_W'(1);
            r_s1 <= '0;
        end
        if (i_cmd.mul) begin
            r_r1 <= prod;
            r_m  <= prod;
        end
        if (i_cmd.div_init) begin
            r_pr <= '0;
            r_dv <= r_r0;
            r_t  <= '0;
        end
        if (i_cmd.div_step) begin
            // Quotient bits arrive most significant first, so quo*s1 builds up by Horner's rule.
            r_pr <= ge ? VALUE_W'(pr_sh - {1'b0, r_r1}) : pr_sh[VALUE_W-1:0];
            r_dv <= {r_dv[VALUE_W-2:0], 1'b0};
            r_t  <= {r_t[COEF_W-2:0], 1'b0} + (ge ? r_s1 : '0);
        end
        if (i_cmd.swap) begin
            r_r0 <= r_r1;
            r_r1 <= r_pr;
            r_s0 <= r_s1;
            r_s1 <= r_s0 - r_t;
        end
        if (i_cmd.fix_a) begin
            r_neg <= r_s0[COEF_W-1];
            r_mag <= r_s0[COEF_W-1] ? '0 - r_s0 : r_s0;
        end
        if (i_cmd.fix_b) begin
            r_inv <= res[VALUE_W-1:0];
            r_no  <= 1'b0;
        end
        if (i_cmd.flag) begin
            r_inv <= '0;
            r_no  <= 1'b1;
        end
    end
endmodule
`default_nettype wire

### src/mie_ctrl.sv
// Controller: sequences the multiply, the Euclid rounds and the final reduction.
`default_nettype none
module mie_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    output logic                   o_done,
    output mie_pkg::t_cmd          o_cmd,
    input  wire mie_pkg::t_status  i_status
);
    import mie_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_CHK, S_DIV, S_SWAP, S_TEST, S_FIXA, S_FIXB
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_done;

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && start;
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.swap     = (r_state == S_SWAP);
        o_cmd.fix_a    = (r_state == S_FIXA);
        o_cmd.fix_b    = (r_state == S_FIXB);
        o_cmd.div_init = ((r_state == S_CHK) && !i_status.m_zero) ||
                         ((r_state == S_TEST) && !i_status.r1_zero);
        o_cmd.flag     = ((r_state == S_CHK) && i_status.m_zero) ||
                         ((r_state == S_TEST) && i_status.r1_zero && !i_status.gcd_one);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) r_state <= S_MUL;
                end
                S_MUL: r_state <= S_CHK;
                S_CHK: begin
                    r_cnt <= '0;
                    if (i_status.m_zero) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(VALUE_W - 1)) r_state <= S_SWAP;
                end
                S_SWAP: r_state <= S_TEST;
                S_TEST: begin
                    r_cnt <= '0;
                    if (!i_status.r1_zero) begin
                        r_state <= S_DIV;
                    end else if (i_status.gcd_one) begin
                        r_state <= S_FIXA;
                    end else begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                S_FIXA: r_state <= S_FIXB;
                S_FIXB: begin
                    r_state <= S_IDLE;
                    r_done  <= 1'b1;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### src/modular_inverse_euclid.sv
// Top level of the modular inverse unit.
// An item is taken when start is high and busy is low; its result appears for one cycle with
// o_done high and cannot be held off. The modulus (prime_a-1)(prime_b-1) is formed first, each
// Euclid round is made of 62 shift-subtract division steps, one swap and one test, and the
// final reduction runs through S_FIXA and S_FIXB. The time is set by the bit-serial divider
// that every round goes through.
`default_nettype none
module modular_inverse_euclid #(
    parameter int PRIME_WIDTH = mie_pkg::PRIME_W_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [mie_pkg::VALUE_W-1:0]  i_exponent,
    input  wire logic [mie_pkg::PRIME_W-1:0]  i_prime_a,
    input  wire logic [mie_pkg::PRIME_W-1:0]  i_prime_b,
    output logic                              o_done,
    output logic      [mie_pkg::VALUE_W-1:0]  o_inverse,
    output logic                              o_no_inverse
);
    import mie_pkg::*;

    t_cmd    cmd;
    t_status status;

    mie_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_done   (o_done),
        .o_cmd    (cmd),
        .i_status (status)
    );

    mie_datapath #(.PRIME_WIDTH(PRIME_WIDTH)) u_dp (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_exponent   (i_exponent),
        .i_prime_a    (i_prime_a),
        .i_prime_b    (i_prime_b),
        .o_inverse    (o_inverse),
        .o_no_inverse (o_no_inverse)
    );
endmodule
`default_nettype wire

### src/mie_checker.sv
// Port-level checker for the modular inverse unit, bound to the top level.
`default_nettype none
module mie_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_done,
    input wire logic [61:0] o_inverse,
    input wire logic        o_no_inverse
);
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("accepted item did not raise busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result shown while still busy");
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("one item gave two results");
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_no_inverse |-> o_inverse == '0) else $error("flagged result not zero");
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy)) else $error("result without an item in work");
endmodule

bind modular_inverse_euclid mie_checker u_mie_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_inverse    (o_inverse),
    .o_no_inverse (o_no_inverse)
);
`default_nettype wire
